FILE: rtl/core/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants and the shift-add-3 digit step for the decimal text unit.
// ----------------------------------------------------------------------------
package b2da_pkg;

   localparam int VALUE_W     = 32;
   localparam int DIGITS      = 10;
   localparam int BCD_W       = 4 * DIGITS;
   localparam int BITS_STAGE  = 8;
   localparam int STAGES      = VALUE_W / BITS_STAGE;
   localparam int TEXT_W      = 64;
   localparam int TDATA_W     = 2 * TEXT_W;

   localparam logic [3:0] DIGIT_FIVE   = 4'd5;
   localparam logic [3:0] DIGIT_ADJUST = 4'd3;
   localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;
   localparam logic [7:0] ASCII_ZERO   = 8'h30;

   typedef logic [BCD_W-1:0] bcd_type;

   // eight double-dabble steps: adjust digits >= 5, then shift in one bit
   function automatic bcd_type dabble_byte(input bcd_type bcd_i,
                                           input logic [BITS_STAGE-1:0] bits_i);
      bcd_type acc;
      acc = bcd_i;
      for (int b = BITS_STAGE - 1; b >= 0; b--) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (acc[4*d +: 4] >= DIGIT_FIVE) begin
               acc[4*d +: 4] = acc[4*d +: 4] + DIGIT_ADJUST;
            end
         end
         acc = {acc[BCD_W-2:0], bits_i[b]};
      end
      return acc;
   endfunction

endpackage

FILE: rtl/core/binary32_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// binary32_to_decimal_ascii_unit
// Converts a 32-bit unsigned value to 16 zero-padded ASCII decimal characters.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req_    | in  | tdata[31:0]   value
//  rsp_    | out | tdata[63:0]   text_high, tdata[127:64] text_low
//
//  Four register stages, each runs eight shift-add-3 steps on one input byte.
//  One transfer per cycle sustained while rsp_tready holds; the result is offered
//  from the last stage register once it has passed through every stage.
//  Stalls ripple back stage by stage; empty stages still accept.
//  Synchronous reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module binary32_to_decimal_ascii_unit
   import b2da_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [VALUE_W-1:0]  req_tdata,   // [31:0] value
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [TDATA_W-1:0]  rsp_tdata    // [63:0] text_high, [127:64] text_low
);

   logic    [STAGES-1:0]  valid_ff;
   logic    [STAGES-1:0]  valid_in;
   logic    [STAGES-1:0]  free;
   bcd_type               bcd_ff  [STAGES];
   bcd_type               bcd_in  [STAGES];
   logic    [VALUE_W-1:0] bin_ff  [STAGES-1];
   logic    [VALUE_W-1:0] bin_in  [STAGES-1];
   logic    [TEXT_W-1:0]  text_high;
   logic    [TEXT_W-1:0]  text_low;

   always_comb begin
      free[STAGES-1] = !valid_ff[STAGES-1] || rsp_tready;
      for (int s = STAGES - 2; s >= 0; s--) begin
         free[s] = !valid_ff[s] || free[s+1];
      end
   end

   assign req_tready = free[0];

   always_comb begin
      valid_in[0] = free[0] ? req_tvalid : valid_ff[0];
      bin_in[0]   = free[0] ? req_tdata : bin_ff[0];
      bcd_in[0]   = free[0] ? dabble_byte('0, req_tdata[VALUE_W-1 -: BITS_STAGE])
                            : bcd_ff[0];
      for (int s = 1; s < STAGES; s++) begin
         valid_in[s] = free[s] ? valid_ff[s-1] : valid_ff[s];
         bcd_in[s]   = free[s]
                     ? dabble_byte(bcd_ff[s-1],
                                   bin_ff[s-1][VALUE_W-1-BITS_STAGE*s -: BITS_STAGE])
                     : bcd_ff[s];
      end
      for (int s = 1; s < STAGES - 1; s++) begin
         bin_in[s]   = free[s] ? bin_ff[s-1] : bin_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         bcd_ff[s] <= bcd_in[s];
      end
      for (int s = 0; s < STAGES - 1; s++) begin
         bin_ff[s] <= bin_in[s];
      end
   end

   always_comb begin
      text_high = {{6{ASCII_ZERO}},
                   ASCII_DIGIT_HI, bcd_ff[STAGES-1][39:36],
                   ASCII_DIGIT_HI, bcd_ff[STAGES-1][35:32]};
      for (int d = 0; d < 8; d++) begin
         text_low[8*d +: 8] = {ASCII_DIGIT_HI, bcd_ff[STAGES-1][4*d +: 4]};
      end
   end

   assign rsp_tvalid = valid_ff[STAGES-1];
   assign rsp_tdata  = {text_low, text_high};

endmodule

FILE: tb/tb_binary32_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary32_to_decimal_ascii_unit
// Streams 32-bit values into the decimal text unit and checks every returned
// 16-character ASCII string against a digit-by-digit conversion. Directed
// edge values come first, then random values of several shapes. Both sides
// idle at random, and one long output hold backs the pipeline up.
// ----------------------------------------------------------------------------
module tb_binary32_to_decimal_ascii_unit;
   import b2da_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 1650;
   localparam int EDGE_COUNT   = 25;
   localparam logic [VALUE_W-1:0] EDGE_VALUES [EDGE_COUNT] = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000, 32'd9999,
      32'd99999, 32'd999999, 32'd9999999, 32'd99999999, 32'd999999999,
      32'd1000000000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF,
      32'hAAAA_AAAA, 32'h5555_5555, 32'd4000000000, 32'd1234567890, 32'd65536,
      32'd255
   };

   typedef struct packed {
      logic [TEXT_W-1:0] text_low;
      logic [TEXT_W-1:0] text_high;
   } text_pair_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [VALUE_W-1:0]  req_tdata  = '0;   // [31:0] value
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [TDATA_W-1:0]  rsp_tdata;         // [63:0] text_high, [127:64] text_low

   logic [VALUE_W-1:0]  pending_values [$];
   text_pair_type       text_expected [$];
   int                  total_items   = 0;
   int                  req_count     = 0;
   int                  rsp_count     = 0;
   int                  req_seen      = 0;
   int                  rsp_seen      = 0;
   int                  send_gap      = 0;
   int                  recv_hold     = 0;
   int                  idle_cycles   = 0;
   int                  errors        = 0;
   bit                  pressure_done = 1'b0;

   binary32_to_decimal_ascii_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic text_pair_type decimal_text(input logic [VALUE_W-1:0] value);
      text_pair_type      t;
      logic [VALUE_W-1:0] rest;
      logic [7:0]         ch;
      int                 pos;
      t = '0;
      rest = value;
      for (pos = 15; pos >= 0; pos--) begin
         ch = ASCII_ZERO + 8'(rest % 10);
         rest = rest / 10;
         if (pos >= 8) begin
            t.text_low[8*(15-pos) +: 8] = ch;
         end else begin
            t.text_high[8*(7-pos) +: 8] = ch;
         end
      end
      return t;
   endfunction

   function automatic logic [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] p;
      int                 k;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: random_value = $urandom;
         4, 5:       random_value = $urandom >> $urandom_range(1, 31);
         6:          random_value = $urandom_range(0, 99);
         7: begin
            p = 1;
            k = $urandom_range(0, 9);
            repeat (k) p = p * 10;
            random_value = p + $urandom_range(0, 2) - 1;
         end
         8:          random_value = 32'hFFFF_FFFF - $urandom_range(0, 1000);
         default: begin
            p = 1;
            k = $urandom_range(1, 9);
            repeat (k) p = p * 10;
            random_value = p * $urandom_range(1, 4);
         end
      endcase
   endfunction

   // stimulus, drain, verdict
   initial begin
      for (int i = 0; i < EDGE_COUNT; i++) pending_values.push_back(EDGE_VALUES[i]);
      for (int i = 0; i < RANDOM_ITEMS; i++) pending_values.push_back(random_value());
      total_items = pending_values.size();
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      wait (req_count == total_items);
      wait (rsp_count == total_items);
      repeat (20) @(posedge clock);
      if (text_expected.size() != 0) begin
         $error("results missing: %0d conversions never returned", text_expected.size());
         errors++;
      end
      $display("covered %0d conversions (%0d edge values, %0d random), %0d mismatches",
               total_items, EDGE_COUNT, RANDOM_ITEMS, errors);
      $display("random idling on both sides, zero-gap bursts, one %0d-cycle output hold",
               HOLD_CYCLES);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // request driver
   always @(negedge clock) begin : drive_values
      logic next_valid;
      next_valid = req_tvalid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_seen != req_count) begin
            req_seen = req_count;
            next_valid = 1'b0;
            send_gap = (((req_count / 150) % 4) == 3) ? 0 : $urandom_range(0, 9);
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_values.size() > 0) begin
               req_tdata <= pending_values.pop_front();
               next_valid = 1'b1;
            end
         end
      end
      req_tvalid <= next_valid;
   end

   // response ready, with one long hold mid-run
   always @(negedge clock) begin : accept_text
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_seen != rsp_count) begin
            rsp_seen = rsp_count;
            recv_hold = (((rsp_count / 170) % 4) == 1) ? 0 : $urandom_range(0, 9);
            if (!pressure_done && rsp_count >= 400) begin
               recv_hold = HOLD_CYCLES;
               pressure_done = 1'b1;
            end
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // transfer monitor and checker
   always @(posedge clock) begin : check_text
      text_pair_type got;
      text_pair_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            rsp_count++;
            if (text_expected.size() == 0) begin
               $error("unexpected transfer: text_high %h text_low %h",
                      got.text_high, got.text_low);
               errors++;
            end else begin
               want = text_expected.pop_front();
               if (got.text_high !== want.text_high) begin
                  $error("text_high: expected %h, actual %h", want.text_high, got.text_high);
                  errors++;
               end
               if (got.text_low !== want.text_low) begin
                  $error("text_low: expected %h, actual %h", want.text_low, got.text_low);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            text_expected.push_back(decimal_text(req_tdata));
            req_count++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

endmodule
